[hw/rtl/cdq_pkg.sv]
// shared types and codes for the circular deque
`default_nettype none

package cdq_pkg;

	// operation codes carried by a command transaction
	typedef enum logic [1:0] {
		OP_INS_REAR  = 2'd0,
		OP_INS_FRONT = 2'd1,
		OP_DEL_FRONT = 2'd2,
		OP_DEL_REAR  = 2'd3
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OCC_W  = 4;

endpackage

`default_nettype wire

[hw/rtl/cdq_cmd_if.sv]
// command channel: opcode and value with valid/ready handshake
`default_nettype none

interface cdq_cmd_if;

	logic                                  valid;
	logic                                  ready;
	cdq_pkg::opcode_t                      opcode;
	logic signed [cdq_pkg::DATA_W-1:0]     value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);

endinterface

`default_nettype wire

[hw/rtl/cdq_res_if.sv]
// result channel: status, removed element and deque snapshot with valid/ready handshake
`default_nettype none

interface cdq_res_if;

	logic                                  valid;
	logic                                  ready;
	cdq_pkg::status_t                      status;
	logic signed [cdq_pkg::DATA_W-1:0]     removed_value;
	logic signed [cdq_pkg::DATA_W-1:0]     first_value;
	logic signed [cdq_pkg::DATA_W-1:0]     last_value;
	logic                                  is_empty;
	logic                                  is_full;
	logic [cdq_pkg::OCC_W-1:0]             occupancy;

	modport source (
		output valid, output status, output removed_value, output first_value,
		output last_value, output is_empty, output is_full, output occupancy,
		input ready
	);
	modport sink (
		input valid, input status, input removed_value, input first_value,
		input last_value, input is_empty, input is_full, input occupancy,
		output ready
	);

endinterface

`default_nettype wire

[hw/rtl/circular_deque.sv]
// Circular double-ended queue of DEPTH signed 32-bit elements. Each command transaction
// inserts at the rear or front or deletes from the front or rear, and yields exactly one
// result transaction with the status (ok, overflow, underflow), the removed element, the
// front and rear elements, empty and full flags and the occupancy after the operation.
// Elements live in a single-port-read, single-port-write synchronous memory; the front and
// rear elements are also held in registers. Inserts, overflows, underflows and deletes that
// empty the deque register their result directly; any other delete first passes through the
// read state, since the new front or rear element is fetched through the memory's registered
// read port. One command is in work at a time; a new command is taken in the cycle its
// predecessor's result is taken, or when the result register is free outside a fetch.
`default_nettype none

module circular_deque #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cdq_cmd_if.sink    cmd,
	cdq_res_if.source  res
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned DW    = cdq_pkg::DATA_W;

	// control state
	cdq_pkg::state_t        state_q, state_d;
	logic [PTR_W-1:0]       head_q, head_d;
	logic [PTR_W-1:0]       tail_q, tail_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic                   rd_front_q, rd_front_d;

	// cached end elements
	logic signed [DW-1:0]   first_q, first_d;
	logic signed [DW-1:0]   last_q, last_d;

	// slot memory
	logic signed [DW-1:0]   mem [DEPTH];
	logic                   wr_en;
	logic [PTR_W-1:0]       wr_addr;
	logic                   rd_en;
	logic [PTR_W-1:0]       rd_addr;
	logic signed [DW-1:0]   rd_data_q;

	// result register
	logic                   out_valid_q;
	cdq_pkg::status_t       out_status_q;
	logic signed [DW-1:0]   out_removed_q;
	logic signed [DW-1:0]   out_first_q;
	logic signed [DW-1:0]   out_last_q;
	logic                   out_empty_q;
	logic                   out_full_q;
	logic [cdq_pkg::OCC_W-1:0] out_occ_q;

	logic                   acc;
	logic                   go_read;
	cdq_pkg::status_t       status_d;
	logic signed [DW-1:0]   removed_d;
	logic                   cnt_full;
	logic                   cnt_zero;
	logic                   cnt_one;
	logic [PTR_W-1:0]       head_next;
	logic [PTR_W-1:0]       head_prev;
	logic [PTR_W-1:0]       tail_next;
	logic [PTR_W-1:0]       tail_prev;

	// handshake
	assign cmd.ready = (state_q == cdq_pkg::S_IDLE) && (!out_valid_q || res.ready);
	assign acc       = cmd.valid && cmd.ready;

	// occupancy and index neighbors
	assign cnt_full  = (count_q == CNT_W'(DEPTH));
	assign cnt_zero  = (count_q == '0);
	assign cnt_one   = (count_q == CNT_W'(1));
	assign head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
	assign tail_next = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? PTR_W'(DEPTH - 1) : tail_q - 1'b1;

	// next state, pointer update and memory access decode
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		first_d    = first_q;
		last_d     = last_q;
		rd_front_d = rd_front_q;
		status_d   = cdq_pkg::ST_OK;
		removed_d  = '0;
		wr_en      = 1'b0;
		wr_addr    = head_q;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		go_read    = 1'b0;
		case (state_q)
			cdq_pkg::S_IDLE: begin
				if (acc) begin
					case (cmd.opcode)
						cdq_pkg::OP_INS_REAR, cdq_pkg::OP_INS_FRONT: begin
							if (cnt_full) begin
								status_d = cdq_pkg::ST_OVERFLOW;
							end else if (cnt_zero) begin
								// first element always lands in slot zero
								head_d  = '0;
								tail_d  = '0;
								wr_en   = 1'b1;
								wr_addr = '0;
								first_d = cmd.value;
								last_d  = cmd.value;
								count_d = count_q + 1'b1;
							end else if (cmd.opcode == cdq_pkg::OP_INS_REAR) begin
								tail_d  = tail_next;
								wr_en   = 1'b1;
								wr_addr = tail_next;
								last_d  = cmd.value;
								count_d = count_q + 1'b1;
							end else begin
								head_d  = head_prev;
								wr_en   = 1'b1;
								wr_addr = head_prev;
								first_d = cmd.value;
								count_d = count_q + 1'b1;
							end
						end
						cdq_pkg::OP_DEL_FRONT, cdq_pkg::OP_DEL_REAR: begin
							if (cnt_zero) begin
								status_d = cdq_pkg::ST_UNDERFLOW;
							end else if (cnt_one) begin
								// last element gone, pointers return to slot zero
								removed_d = first_q;
								head_d    = '0;
								tail_d    = '0;
								count_d   = '0;
							end else if (cmd.opcode == cdq_pkg::OP_DEL_FRONT) begin
								removed_d  = first_q;
								head_d     = head_next;
								count_d    = count_q - 1'b1;
								rd_en      = 1'b1;
								rd_addr    = head_next;
								rd_front_d = 1'b1;
								go_read    = 1'b1;
								state_d    = cdq_pkg::S_READ;
							end else begin
								removed_d  = last_q;
								tail_d     = tail_prev;
								count_d    = count_q - 1'b1;
								rd_en      = 1'b1;
								rd_addr    = tail_prev;
								rd_front_d = 1'b0;
								go_read    = 1'b1;
								state_d    = cdq_pkg::S_READ;
							end
						end
						default: begin
							status_d = cdq_pkg::ST_OK;
						end
					endcase
				end
			end
			cdq_pkg::S_READ: begin
				// new end element arrives from memory
				state_d = cdq_pkg::S_IDLE;
				if (rd_front_q) begin
					first_d = rd_data_q;
				end else begin
					last_d = rd_data_q;
				end
			end
			default: begin
				state_d = cdq_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cdq_pkg::S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			rd_front_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			rd_front_q <= rd_front_d;
		end
	end

	// cached end elements
	always_ff @(posedge clk) begin
		first_q <= first_d;
		last_q  <= last_d;
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((acc && !go_read) || (state_q == cdq_pkg::S_READ)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_status_q  <= status_d;
			out_removed_q <= removed_d;
			out_first_q   <= (count_d == '0) ? '0 : first_d;
			out_last_q    <= (count_d == '0) ? '0 : last_d;
			out_empty_q   <= (count_d == '0);
			out_full_q    <= (count_d == CNT_W'(DEPTH));
			out_occ_q     <= cdq_pkg::OCC_W'(count_d);
		end else if (state_q == cdq_pkg::S_READ) begin
			out_first_q <= first_d;
			out_last_q  <= last_d;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.removed_value = out_removed_q;
	assign res.first_value   = out_first_q;
	assign res.last_value    = out_last_q;
	assign res.is_empty      = out_empty_q;
	assign res.is_full       = out_full_q;
	assign res.occupancy     = out_occ_q;

`ifndef SYNTHESIS
	// no command is taken while a memory fetch is outstanding
	a_no_take_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdq_pkg::S_READ) |-> !cmd.ready)
		else $error("command accepted during memory fetch");

	// a successful insert grows the count by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !cmd.opcode[1] && !cnt_full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the count");

	// an empty result shows zero end elements
	a_empty_zero_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.is_empty) |-> (res.first_value == '0 && res.last_value == '0))
		else $error("empty result carries nonzero end element");

	// the count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (count_q <= CNT_W'(DEPTH)))
		else $error("element count above depth");
`endif

endmodule

`default_nettype wire
